### rtl/core/fir_filter_ring_buffer_top_assert.svh
// Assertion macros shared by the checker files of the filter block.
// Depends on nothing; the users supply clk_i and rst_ni in their scope.
`ifndef FIR_FILTER_RING_BUFFER_TOP_ASSERT_SVH
`define FIR_FILTER_RING_BUFFER_TOP_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define FIRRB_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("filter port assertion failed");

// Concurrent assertion on the usual clk_i and rst_ni of the enclosing module.
`define FIRRB_ASSERT(lbl, prop) `FIRRB_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### rtl/core/firrb_pkg.sv
// Package of the FIR filter block: sizes, coefficient table and state encoding.
// Used by every module of the block; depends on nothing.
`default_nettype none

package firrb_pkg;

  localparam int unsigned TAPS_DEF        = 15;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS       = 15;
  localparam int unsigned COEF_W          = 16;
  localparam int unsigned COEF_IDX_W      = 6;
  // Must stay a power of two so that the queue pointers wrap on their own.
  localparam int unsigned QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } firrb_state_e;

  // Symmetric low-pass taps in Q1.15; taps beyond the fifteenth are zero.
  function automatic logic signed [COEF_W-1:0] coeff(input logic [COEF_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      6'd0:    c = -16'sd115;
      6'd1:    c = -16'sd128;
      6'd2:    c = 16'sd0;
      6'd3:    c = 16'sd672;
      6'd4:    c = 16'sd2123;
      6'd5:    c = 16'sd4099;
      6'd6:    c = 16'sd5852;
      6'd7:    c = 16'sd6554;
      6'd8:    c = 16'sd5852;
      6'd9:    c = 16'sd4099;
      6'd10:   c = 16'sd2123;
      6'd11:   c = 16'sd672;
      6'd12:   c = 16'sd0;
      6'd13:   c = -16'sd128;
      6'd14:   c = -16'sd115;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/firrb_if.sv
// Valid/ready channel interfaces for the filter's samples and results.
// Depends on nothing; widths come from the WIDTH parameter.
`default_nettype none

interface firrb_sample_if #(
  parameter int unsigned WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface firrb_filtered_if #(
  parameter int unsigned WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

### rtl/core/firrb_front.sv
// Front end of the filter: accepts input items into a short sample queue.
// Depends on firrb_pkg and firrb_sample_if.
`default_nettype none

module firrb_front #(
  parameter int unsigned SAMPLE_BITS = firrb_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  firrb_sample_if.sink   in_i,
  firrb_sample_if.source q_o
);

  localparam int unsigned DEPTH = firrb_pkg::QUEUE_DEPTH;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic signed [SAMPLE_BITS-1:0] slot_q [DEPTH];
  logic [IDX_W-1:0]              wr_q, wr_d;
  logic [IDX_W-1:0]              rd_q, rd_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          push, pop;

  assign in_i.ready = (cnt_q != FULL);
  assign q_o.valid  = (cnt_q != '0);
  assign q_o.sample = slot_q[rd_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = q_o.valid && q_o.ready;

  always_comb begin
    wr_d  = push ? wr_q + IDX_W'(1) : wr_q;
    rd_d  = pop ? rd_q + IDX_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_i.sample;
    end
  end

endmodule

`default_nettype wire

### rtl/core/firrb_mac.sv
// Back end of the filter: ring store of past samples, one shared multiply-
// accumulate unit stepped over the taps, rounding, saturation and result register.
// Depends on firrb_pkg, firrb_sample_if and firrb_filtered_if.
`default_nettype none

module firrb_mac #(
  parameter int unsigned TAPS        = firrb_pkg::TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = firrb_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  firrb_sample_if.sink     q_i,
  firrb_filtered_if.source out_o
);

  localparam int unsigned PTR_W  = $clog2(TAPS);
  localparam int unsigned CNT_W  = $clog2(TAPS + 1);
  localparam int unsigned CW     = firrb_pkg::COEF_W;
  localparam int unsigned CIW    = firrb_pkg::COEF_IDX_W;
  localparam int unsigned FB     = firrb_pkg::FRAC_BITS;
  localparam int unsigned PROD_W = SAMPLE_BITS + CW;
  localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS) + 1;

  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(TAPS - 1);
  localparam logic [CNT_W-1:0] TAP_COUNT = CNT_W'(TAPS);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FB - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  firrb_pkg::firrb_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] mem_q [TAPS];
  logic [TAPS-1:0]               valid_q;
  logic [PTR_W-1:0]              wp_q;
  logic [CNT_W-1:0]              iss_cnt_q;
  logic [PTR_W-1:0]              iss_addr_q;
  logic                          s1_v_q, s2_v_q, rd_ok_q;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic signed [CW-1:0]          coef_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;

  logic                          pop, issue, iss_done, out_load;
  logic signed [SAMPLE_BITS-1:0] sample_eff;
  logic signed [ACC_W-1:0]       rounded, shifted;
  logic signed [SAMPLE_BITS-1:0] sat_res;

  assign iss_done = (iss_cnt_q == TAP_COUNT);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      firrb_pkg::ST_IDLE: begin
        if (q_i.valid) begin
          state_d = firrb_pkg::ST_RUN;
        end
      end
      firrb_pkg::ST_RUN: begin
        if (iss_done && !s1_v_q && !s2_v_q) begin
          state_d = firrb_pkg::ST_WRITE;
        end
      end
      firrb_pkg::ST_WRITE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = firrb_pkg::ST_IDLE;
        end
      end
      default: state_d = firrb_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_i.ready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      firrb_pkg::ST_IDLE:  q_i.ready = 1'b1;
      firrb_pkg::ST_RUN:   issue = !iss_done;
      firrb_pkg::ST_WRITE: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign pop = q_i.valid && q_i.ready;

  // Entries never written since reset read as zero.
  assign sample_eff = rd_ok_q ? rd_data_q : '0;

  // Round half up, then floor shift back to Q1.15 and clamp.
  assign rounded = acc_q + HALF;
  assign shifted = rounded >>> FB;
  always_comb begin
    if (shifted > SAT_MAX) begin
      sat_res = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_MIN) begin
      sat_res = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_res = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= firrb_pkg::ST_IDLE;
      valid_q     <= '0;
      wp_q        <= '0;
      iss_cnt_q   <= TAP_COUNT;
      iss_addr_q  <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      if (pop) begin
        valid_q[wp_q] <= 1'b1;
        wp_q          <= (wp_q == LAST_PTR) ? '0 : wp_q + PTR_W'(1);
        iss_cnt_q     <= '0;
        // The newest sample is tap 0; older ones sit at falling positions.
        iss_addr_q    <= wp_q;
      end else if (issue) begin
        iss_cnt_q  <= iss_cnt_q + CNT_W'(1);
        iss_addr_q <= (iss_addr_q == '0) ? LAST_PTR : iss_addr_q - PTR_W'(1);
      end
      if (issue) begin
        rd_ok_q <= valid_q[iss_addr_q];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      mem_q[wp_q] <= q_i.sample;
    end
    if (issue) begin
      rd_data_q <= mem_q[iss_addr_q];
      coef_q    <= firrb_pkg::coeff(CIW'(iss_cnt_q));
    end
    if (s1_v_q) begin
      prod_q <= sample_eff * coef_q;
    end
    if (pop) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (out_load) begin
      out_data_q <= sat_res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fir_filter_ring_buffer_top.sv
// Direct-form low-pass FIR filter with a ring store of past samples.
//
// Channels: in_i carries one signed Q1.15 sample per item, out_o one filtered
// Q1.15 sample per item; both use valid/ready and move an item when both are high.
// Every input item gives exactly one result item, in order.
// A two-entry sample queue takes items while the back end is busy, and the
// result register holds a finished result while the back end starts on the next.
// The back end steps one shared multiplier over the taps, one tap per cycle, and
// takes no new item before the last one is in the result register; that loop
// sets the sustained throughput.
// Reset clears the ring store (older samples read as zero until written), the
// write position, the queue and the result register.
// When the receiver stalls, the result is held; the back end finishes the next
// item and waits for the register, and the queue fills and then drops ready.
// Depends on firrb_pkg, firrb_if, firrb_front and firrb_mac.
`default_nettype none

module fir_filter_ring_buffer_top #(
  parameter int unsigned TAPS        = firrb_pkg::TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = firrb_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  firrb_sample_if.sink     in_i,
  firrb_filtered_if.source out_o
);

  firrb_sample_if #(.WIDTH(SAMPLE_BITS)) q_if ();

  firrb_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q_if)
  );

  firrb_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_if),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

### rtl/core/firrb_checker.sv
// Port-level checks of the filter block, attached to the top level by bind.
// Depends on fir_filter_ring_buffer_top_assert.svh.
`default_nettype none
`include "fir_filter_ring_buffer_top_assert.svh"

module firrb_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [SAMPLE_BITS-1:0] out_filtered_i
);

  // Items accepted but not yet delivered: queue, back end and result register.
  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  `FIRRB_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `FIRRB_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_filtered_i))
  `FIRRB_ASSERT(a_no_spurious, out_valid_i |-> pending_q != 3'd0)
  `FIRRB_ASSERT(a_bounded, pending_q < 3'd5)

endmodule

bind fir_filter_ring_buffer_top firrb_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_filtered_i (out_o.filtered)
);

`default_nettype wire

### test/tb_fir_filter_ring_buffer_top.sv
// Self-checking testbench for the 15-tap ring-store FIR filter top level.
// Sends samples and compares every filtered item with a predictor of its own.
// Depends on firrb_pkg, firrb_if and fir_filter_ring_buffer_top.
`timescale 1ns / 100ps

module tb_fir_filter_ring_buffer_top;

  localparam int unsigned NTAPS     = firrb_pkg::TAPS_DEF;
  localparam int unsigned SW        = firrb_pkg::SAMPLE_BITS_DEF;
  localparam int          IDLE_PCT  = 31;
  localparam int          DRAIN_CYC = 40;
  localparam longint      LIMIT     = 400000;
  localparam longint      SMP_MAX   = (longint'(1) << (SW - 1)) - 1;
  localparam longint      SMP_MIN   = -SMP_MAX - 1;
  localparam int          TAP_COEF [15] = '{-115, -128, 0, 672, 2123, 4099, 5852, 6554,
                                            5852, 4099, 2123, 672, 0, -128, -115};

  logic clk;
  logic rst_n;
  logic idle_en;
  longint cycle_cnt;
  int err_cnt;

  // Expected filtered items, oldest first.
  logic signed [SW-1:0] filtered_q [$];
  // Predictor state: past samples and the position of the next write.
  logic signed [SW-1:0] hist_store [NTAPS];
  logic [3:0]           hist_pos;

  firrb_sample_if   #(.WIDTH(SW)) smp_if ();
  firrb_filtered_if #(.WIDTH(SW)) flt_if ();

  fir_filter_ring_buffer_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (smp_if),
    .out_o (flt_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Writes one sample into the ring and returns the rounded, saturated sum.
  function automatic logic signed [SW-1:0] filter_next(input logic signed [SW-1:0] s);
    longint acc;
    longint res;
    int     idx;
    hist_store[hist_pos] = s;
    hist_pos = (hist_pos == NTAPS - 1) ? 4'd0 : hist_pos + 4'd1;
    acc = 0;
    idx = hist_pos;
    for (int n = 0; n < NTAPS; n++) begin
      idx = (idx == 0) ? NTAPS - 1 : idx - 1;
      acc += longint'(TAP_COEF[n]) * longint'(hist_store[idx]);
    end
    // Arithmetic shift floors, so exact halves go towards plus infinity.
    res = (acc + (longint'(1) << (firrb_pkg::FRAC_BITS - 1))) >>> firrb_pkg::FRAC_BITS;
    if (res > SMP_MAX) res = SMP_MAX;
    if (res < SMP_MIN) res = SMP_MIN;
    return res[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    logic [SW-1:0] r;
    r = SW'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       r = {1'b0, {(SW-1){1'b1}}};
        1:       r = {1'b1, {(SW-1){1'b0}}};
        2:       r = '0;
        default: r = '1;
      endcase
    end
    return r;
  endfunction

  // Drives one sample and returns at the edge where it is accepted.
  task automatic send_sample(input logic signed [SW-1:0] s);
    @(negedge clk);
    if (idle_en) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        smp_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    filtered_q.push_back(filter_next(s));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    smp_if.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  // Fresh store: a lone 16384 or -16384 lands exactly on a half.
  task automatic test_startup_rounding();
    send_sample(16'sd16384);
    send_sample(-16'sd16384);
  endtask

  task automatic test_field_extremes();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
  endtask

  // Full-scale samples whose signs follow the taps give the largest output.
  task automatic test_peak_gain();
    for (int i = 0; i < NTAPS; i++)
      send_sample(TAP_COEF[i] < 0 ? 16'sh8000 : 16'sh7fff);
  endtask

  task automatic test_random_idle(input int n);
    idle_en = 1'b1;
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  task automatic test_back_to_back(input int n);
    idle_en = 1'b0;
    for (int i = 0; i < n; i++) send_sample(pick_sample());
    idle_en = 1'b1;
  endtask

  task automatic test_drain_then_resume(input int rounds, input int n);
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      wait_drained();
    end
  endtask

  // Runs of one value let the output settle on the step response.
  task automatic test_step_runs(input int runs);
    logic signed [SW-1:0] v;
    int len;
    for (int r = 0; r < runs; r++) begin
      v   = pick_sample();
      len = $urandom_range(1, 2 * NTAPS);
      for (int i = 0; i < len; i++) send_sample(v);
    end
  endtask

  // Receiver: stalls at random while idling is on.
  always @(negedge clk)
    flt_if.ready <= idle_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;

  always @(posedge clk) begin
    if (rst_n && flt_if.valid && flt_if.ready) begin
      if (filtered_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected item, expected none actual %0d", $time, flt_if.filtered);
      end else begin
        if (flt_if.filtered !== filtered_q[0]) begin
          err_cnt++;
          $display("%0t: filtered mismatch, expected %0d actual %0d",
                   $time, filtered_q[0], flt_if.filtered);
        end
        void'(filtered_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    idle_en       = 1'b1;
    cycle_cnt     = 0;
    err_cnt       = 0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    flt_if.ready  = 1'b0;
    hist_pos      = '0;
    foreach (hist_store[i]) hist_store[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_startup_rounding();
    test_field_extremes();
    test_peak_gain();
    test_random_idle(450);
    test_back_to_back(250);
    test_drain_then_resume(2, 40);
    test_step_runs(18);

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
